// ===== rtl/vns_pkg.sv =====
// ----------------------------------------------------------------------------
// vns_pkg
// Shared widths, transaction types and state encodings of the interface-normal
// stencil.
// ----------------------------------------------------------------------------
package vns_pkg;

  localparam int MAX_DIM     = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int DIM_W       = 7;   // size registers
  localparam int POS_W       = 6;   // raster position and cell index
  localparam int XY_W        = 13;  // plane size up to MAX_DIM * MAX_DIM
  localparam int HIST_AW     = 14;  // history ring address
  localparam int GRAD_W      = 22;  // signed weighted gradient sum
  localparam int MAG_W       = 30;  // normalized magnitude
  localparam int ROOT_W      = 32;  // square root result
  localparam int QUO_W       = 18;  // division quotient
  localparam int NUM_W       = 47;  // division numerator
  localparam int OUT_W       = 16;
  localparam int Q_AW        = 2;   // job queue depth 4
  localparam int AHEAD_BIT   = 12;  // front may lead the oldest job by 4096 samples

  typedef enum logic [1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0] x;
    logic [DIM_W-1:0] y;
    logic [DIM_W-1:0] z;
  } sizes_t;

  typedef struct packed {
    logic                   en;
    logic [HIST_AW-1:0]     addr;
    logic [SAMPLE_BITS-1:0] data;
  } hist_wr_t;

  typedef struct packed {
    logic [HIST_AW-1:0] waddr;
    logic [DIM_W-1:0]   size_x;
    logic [XY_W-1:0]    size_xy;
    logic [POS_W-1:0]   cx;
    logic [POS_W-1:0]   cy;
    logic [POS_W-1:0]   cz;
    logic               last;
  } job_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic signed [GRAD_W-1:0] gz;
    logic [POS_W-1:0]         cx;
    logic [POS_W-1:0]         cy;
    logic [POS_W-1:0]         cz;
    logic                     last;
  } grad_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_TAP,
    B_DRAIN,
    B_HAND
  } back_state_t;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SHIFT,
    N_SQ,
    N_ROOT,
    N_DLOAD,
    N_DIV,
    N_DSAT,
    N_FIN
  } norm_state_t;

  function automatic logic [DIM_W-1:0] clamp_size(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < DIM_W'(3)) r = DIM_W'(3);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    return r;
  endfunction

endpackage

// ===== rtl/vns_front.sv =====
// ----------------------------------------------------------------------------
// vns_front
// Accepts samples, writes the history ring, tracks the raster position and
// queues a job for every cell whose neighborhood is complete.
// ----------------------------------------------------------------------------
module vns_front import vns_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  sizes_t                 sizes,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] fraction,
  output hist_wr_t               hist_wr,
  output logic                   push,
  output job_t                   push_job,
  input  logic                   q_full,
  input  logic                   inflight,
  input  logic [HIST_AW-1:0]     oldest_waddr
);

  logic [DIM_W-1:0]     size_x, size_y, size_z;
  logic [2*DIM_W-1:0]   prod_xy;
  logic [POS_W-1:0]     pos_x, pos_y, pos_z;
  logic [POS_W-1:0]     pos_x_next, pos_y_next, pos_z_next;
  logic [HIST_AW-1:0]   wptr;
  logic [HIST_AW-1:0]   ahead;
  logic [DIM_W-1:0]     ex, ey, ez;
  logic [DIM_W-1:0]     inc_x, inc_y, inc_z;
  logic                 accept, emit;

  assign size_x  = clamp_size(sizes.x);
  assign size_y  = clamp_size(sizes.y);
  assign size_z  = clamp_size(sizes.z);
  assign prod_xy = size_x * size_y;

  assign ex = {1'b0, pos_x};
  assign ey = {1'b0, pos_y};
  assign ez = {1'b0, pos_z};

  // keep the oldest pending job's taps from being overwritten
  assign ahead    = wptr - oldest_waddr;
  assign in_ready = !q_full && !(inflight && (ahead[HIST_AW-1:AHEAD_BIT] != '0));
  assign accept   = in_valid && in_ready;

  assign emit = (pos_x >= POS_W'(2)) && (pos_y >= POS_W'(2)) && (pos_z >= POS_W'(2)) &&
                (ex < size_x) && (ey < size_y) && (ez < size_z);

  assign hist_wr.en   = accept;
  assign hist_wr.addr = wptr;
  assign hist_wr.data = fraction;

  assign push              = accept && emit;
  assign push_job.waddr    = wptr;
  assign push_job.size_x   = size_x;
  assign push_job.size_xy  = prod_xy[XY_W-1:0];
  assign push_job.cx       = pos_x - POS_W'(1);
  assign push_job.cy       = pos_y - POS_W'(1);
  assign push_job.cz       = pos_z - POS_W'(1);
  assign push_job.last     = (ex == size_x - DIM_W'(1)) && (ey == size_y - DIM_W'(1)) &&
                             (ez == size_z - DIM_W'(1));

  assign inc_x = ex + DIM_W'(1);
  assign inc_y = ey + DIM_W'(1);
  assign inc_z = ez + DIM_W'(1);

  always_comb begin
    pos_x_next = pos_x;
    pos_y_next = pos_y;
    pos_z_next = pos_z;
    if (inc_x >= size_x) begin
      pos_x_next = '0;
      if (inc_y >= size_y) begin
        pos_y_next = '0;
        if (inc_z >= size_z) pos_z_next = '0;
        else pos_z_next = inc_z[POS_W-1:0];
      end else begin
        pos_y_next = inc_y[POS_W-1:0];
      end
    end else begin
      pos_x_next = inc_x[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
      wptr  <= '0;
    end else if (accept) begin
      pos_x <= pos_x_next;
      pos_y <= pos_y_next;
      pos_z <= pos_z_next;
      wptr  <= wptr + HIST_AW'(1);
    end
  end

endmodule

// ===== rtl/vns_fifo.sv =====
// ----------------------------------------------------------------------------
// vns_fifo
// Short job queue between the front and the gradient engine.
// ----------------------------------------------------------------------------
module vns_fifo import vns_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic empty
);

  job_t            slots [2**Q_AW];
  logic [Q_AW-1:0] rd_ptr, wr_ptr;
  logic [Q_AW:0]   count;

  assign full  = (count == (Q_AW+1)'(2**Q_AW));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + Q_AW'(1);
      if (pop) rd_ptr <= rd_ptr + Q_AW'(1);
      if (push && !pop) count <= count + (Q_AW+1)'(1);
      else if (pop && !push) count <= count - (Q_AW+1)'(1);
    end
  end

endmodule

// ===== rtl/vns_back.sv =====
// ----------------------------------------------------------------------------
// vns_back
// Holds the sample history ring and walks the 27 taps of a job, one read per
// cycle, accumulating the weighted central differences on all three axes.
// ----------------------------------------------------------------------------
module vns_back import vns_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  hist_wr_t           hist_wr,
  input  job_t               head,
  input  logic               empty,
  output logic               pop,
  output logic               busy,
  output logic [HIST_AW-1:0] busy_waddr,
  output logic               grad_valid,
  output grad_t              grad,
  input  logic               grad_ready
);

  logic [SAMPLE_BITS-1:0] hist [2**HIST_AW];
  logic [SAMPLE_BITS-1:0] rdata;

  back_state_t state, state_next;
  job_t        job;
  logic [1:0]  ti, tj, tk;     // backward steps along x, y, z
  logic [1:0]  ri, rj, rk;
  logic        rv;
  logic        tap_last;

  logic [DIM_W:0]     off_y;
  logic [XY_W:0]      off_z;
  logic [HIST_AW:0]   back_off;
  logic [HIST_AW-1:0] raddr;

  logic signed [GRAD_W-1:0] acc_x, acc_y, acc_z;
  logic signed [GRAD_W-1:0] v_ext;
  logic [1:0]               sh_x, sh_y, sh_z;

  always_comb begin
    unique case (tj)
      2'd0:    off_y = '0;
      2'd1:    off_y = {1'b0, job.size_x};
      default: off_y = {job.size_x, 1'b0};
    endcase
    unique case (tk)
      2'd0:    off_z = '0;
      2'd1:    off_z = {1'b0, job.size_xy};
      default: off_z = {job.size_xy, 1'b0};
    endcase
  end

  assign back_off = (HIST_AW+1)'(ti) + (HIST_AW+1)'(off_y) + (HIST_AW+1)'(off_z);
  assign raddr    = job.waddr - back_off[HIST_AW-1:0];
  assign tap_last = (ti == 2'd2) && (tj == 2'd2) && (tk == 2'd2);

  always_ff @(posedge clk) begin
    if (hist_wr.en) hist[hist_wr.addr] <= hist_wr.data;
  end

  always_ff @(posedge clk) begin
    rdata <= hist[raddr];
  end

  assign busy       = (state == B_TAP) || (state == B_DRAIN);
  assign busy_waddr = job.waddr;

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    grad_valid = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          state_next = B_TAP;
        end
      end
      B_TAP: begin
        if (tap_last) state_next = B_DRAIN;
      end
      B_DRAIN: state_next = B_HAND;
      B_HAND: begin
        grad_valid = 1'b1;
        if (grad_ready) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      rv    <= 1'b0;
    end else begin
      state <= state_next;
      rv    <= (state == B_TAP);
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && !empty) begin
      job <= head;
      ti  <= '0;
      tj  <= '0;
      tk  <= '0;
    end else if (state == B_TAP) begin
      if (ti == 2'd2) begin
        ti <= '0;
        if (tj == 2'd2) begin
          tj <= '0;
          tk <= tk + 2'd1;
        end else begin
          tj <= tj + 2'd1;
        end
      end else begin
        ti <= ti + 2'd1;
      end
    end
    ri <= ti;
    rj <= tj;
    rk <= tk;
  end

  // weight 2 on the center row of each transverse axis
  assign v_ext = {{(GRAD_W-SAMPLE_BITS){1'b0}}, rdata};
  assign sh_x  = {1'b0, rj == 2'd1} + {1'b0, rk == 2'd1};
  assign sh_y  = {1'b0, ri == 2'd1} + {1'b0, rk == 2'd1};
  assign sh_z  = {1'b0, ri == 2'd1} + {1'b0, rj == 2'd1};

  always_ff @(posedge clk) begin
    if (state == B_IDLE) begin
      acc_x <= '0;
      acc_y <= '0;
      acc_z <= '0;
    end else if (rv) begin
      if (ri == 2'd0) acc_x <= acc_x + (v_ext <<< sh_x);
      else if (ri == 2'd2) acc_x <= acc_x - (v_ext <<< sh_x);
      if (rj == 2'd0) acc_y <= acc_y + (v_ext <<< sh_y);
      else if (rj == 2'd2) acc_y <= acc_y - (v_ext <<< sh_y);
      if (rk == 2'd0) acc_z <= acc_z + (v_ext <<< sh_z);
      else if (rk == 2'd2) acc_z <= acc_z - (v_ext <<< sh_z);
    end
  end

  assign grad.gx   = acc_x;
  assign grad.gy   = acc_y;
  assign grad.gz   = acc_z;
  assign grad.cx   = job.cx;
  assign grad.cy   = job.cy;
  assign grad.cz   = job.cz;
  assign grad.last = job.last;

endmodule

// ===== rtl/vns_norm.sv =====
// ----------------------------------------------------------------------------
// vns_norm
// Scales a nonzero gradient to unit length in Q1.15: shift search, sum of
// squares, bit-serial square root and one restoring division per component.
// ----------------------------------------------------------------------------
module vns_norm import vns_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    grad_valid,
  input  grad_t                   grad,
  output logic                    grad_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] normal_x,
  output logic signed [OUT_W-1:0] normal_y,
  output logic signed [OUT_W-1:0] normal_z,
  output logic [POS_W-1:0]        cell_x,
  output logic [POS_W-1:0]        cell_y,
  output logic [POS_W-1:0]        cell_z,
  output logic                    zero_gradient,
  output logic                    last_cell
);

  norm_state_t state, state_next;

  logic [MAG_W-1:0]   mag [3];
  logic [2:0]         neg;
  logic [POS_W-1:0]   cx, cy, cz;
  logic               last, zero;
  logic [2:0]         cnt;
  logic [1:0]         comp;
  logic [2*MAG_W-1:0] prod;
  logic [2*MAG_W+1:0] sumsq;
  logic [63:0]        rv, rres, rbit, rtry;
  logic [ROOT_W-1:0]  root;
  logic [ROOT_W-1:0]  rem;
  logic [ROOT_W:0]    rem2;
  logic [QUO_W-1:0]   lo, quo;
  logic [NUM_W-1:0]   num;
  logic [4:0]         dstep;
  logic [OUT_W-1:0]   res [3];
  logic [QUO_W-1:0]   qsat;
  logic [GRAD_W-1:0]  ax, ay, az;

  assign ax = grad.gx[GRAD_W-1] ? GRAD_W'(-grad.gx) : grad.gx;
  assign ay = grad.gy[GRAD_W-1] ? GRAD_W'(-grad.gy) : grad.gy;
  assign az = grad.gz[GRAD_W-1] ? GRAD_W'(-grad.gz) : grad.gz;

  assign rtry = rres + rbit;
  assign num  = {1'b0, mag[comp], 16'b0} + NUM_W'(root >> 1);
  assign rem2 = {rem, lo[QUO_W-1]};

  always_comb begin
    state_next = state;
    grad_ready = 1'b0;
    unique case (state)
      N_IDLE: begin
        grad_ready = 1'b1;
        if (grad_valid) begin
          if ((ax | ay | az) == '0) state_next = N_FIN;
          else state_next = N_SHIFT;
        end
      end
      N_SHIFT: begin
        if (mag[0][MAG_W-1] | mag[1][MAG_W-1] | mag[2][MAG_W-1]) state_next = N_SQ;
      end
      N_SQ: if (cnt == 3'd3) state_next = N_ROOT;
      N_ROOT: if (rbit == '0) state_next = N_DLOAD;
      N_DLOAD: state_next = N_DIV;
      N_DIV: if (dstep == '0) state_next = N_DSAT;
      N_DSAT: state_next = (comp == 2'd2) ? N_FIN : N_DLOAD;
      N_FIN: if (!out_valid || out_ready) state_next = N_IDLE;
      default: state_next = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= N_IDLE;
    else state <= state_next;
  end

  always_comb begin
    if (!neg[comp]) qsat = (quo > QUO_W'(32767)) ? QUO_W'(32767) : quo;
    else qsat = (quo > QUO_W'(32768)) ? QUO_W'(32768) : quo;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      N_IDLE: begin
        if (grad_valid) begin
          mag[0] <= MAG_W'(ax);
          mag[1] <= MAG_W'(ay);
          mag[2] <= MAG_W'(az);
          neg    <= {grad.gz[GRAD_W-1], grad.gy[GRAD_W-1], grad.gx[GRAD_W-1]};
          cx     <= grad.cx;
          cy     <= grad.cy;
          cz     <= grad.cz;
          last   <= grad.last;
          zero   <= ((ax | ay | az) == '0);
          res[0] <= '0;
          res[1] <= '0;
          res[2] <= '0;
          cnt    <= '0;
          sumsq  <= '0;
        end
      end
      N_SHIFT: begin
        if (!(mag[0][MAG_W-1] | mag[1][MAG_W-1] | mag[2][MAG_W-1])) begin
          mag[0] <= mag[0] << 1;
          mag[1] <= mag[1] << 1;
          mag[2] <= mag[2] << 1;
        end
      end
      N_SQ: begin
        // square is registered before it is summed
        if (cnt != 3'd3) prod <= mag[cnt[1:0]] * mag[cnt[1:0]];
        if (cnt != 3'd0) sumsq <= sumsq + (2*MAG_W+2)'(prod);
        cnt <= cnt + 3'd1;
        if (cnt == 3'd3) begin
          rv   <= {sumsq + (2*MAG_W+2)'(prod), 2'b00};
          rres <= '0;
          rbit <= 64'h4000_0000_0000_0000;
        end
      end
      N_ROOT: begin
        if (rbit != '0) begin
          if (rv >= rtry) begin
            rv   <= rv - rtry;
            rres <= (rres >> 1) + rbit;
          end else begin
            rres <= rres >> 1;
          end
          rbit <= rbit >> 2;
        end else begin
          root <= rres[ROOT_W-1:0];
          comp <= '0;
        end
      end
      N_DLOAD: begin
        rem   <= ROOT_W'(num[NUM_W-1:QUO_W]);
        lo    <= num[QUO_W-1:0];
        quo   <= '0;
        dstep <= 5'(QUO_W-1);
      end
      N_DIV: begin
        if (rem2 >= {1'b0, root}) begin
          rem <= ROOT_W'(rem2 - {1'b0, root});
          quo <= {quo[QUO_W-2:0], 1'b1};
        end else begin
          rem <= rem2[ROOT_W-1:0];
          quo <= {quo[QUO_W-2:0], 1'b0};
        end
        lo    <= lo << 1;
        dstep <= dstep - 5'd1;
      end
      N_DSAT: begin
        res[comp] <= neg[comp] ? OUT_W'(QUO_W'(0) - qsat) : qsat[OUT_W-1:0];
        comp      <= comp + 2'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == N_FIN && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == N_FIN && (!out_valid || out_ready)) begin
      normal_x      <= res[0];
      normal_y      <= res[1];
      normal_z      <= res[2];
      cell_x        <= cx;
      cell_y        <= cy;
      cell_z        <= cz;
      zero_gradient <= zero;
      last_cell     <= last;
    end
  end

endmodule

// ===== rtl/vof_interface_normal_stencil_top.sv =====
// ----------------------------------------------------------------------------
// vof_interface_normal_stencil_top
// Youngs-method interface normal over a streamed, padded 3D volume-fraction
// grid.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    fraction
//   out      out_valid / out_ready  normal_x/y/z, cell_x/y/z, zero_gradient,
//                                   last_cell
//   cfg      cfg_write              cfg_index, cfg_data
//
// Every sample stalls while the job queue is full. A sample that completes
// a neighborhood queues a job: the gradient engine reads its 27 taps from
// the history ring, and the normalizer runs a shift search, sum of squares,
// bit-serial square root and three restoring divisions. Each takes a new job
// only after it has handed on the last one. Up to four jobs wait in the
// queue; the front also stalls when it would lead the oldest job by 4096
// samples. Reset clears control only; the history ring is not cleared.
// ----------------------------------------------------------------------------
module vof_interface_normal_stencil_top import vns_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [1:0]              cfg_index,
  input  logic [DIM_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_BITS-1:0]  fraction,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] normal_x,
  output logic signed [OUT_W-1:0] normal_y,
  output logic signed [OUT_W-1:0] normal_z,
  output logic [POS_W-1:0]        cell_x,
  output logic [POS_W-1:0]        cell_y,
  output logic [POS_W-1:0]        cell_z,
  output logic                    zero_gradient,
  output logic                    last_cell
);

  sizes_t             sizes;
  hist_wr_t           hist_wr;
  job_t               push_job, head;
  logic               push, q_full, pop, empty;
  logic               busy, inflight;
  logic [HIST_AW-1:0] busy_waddr, oldest_waddr;
  logic               grad_valid, grad_ready;
  grad_t              grad;

  always_ff @(posedge clk) begin
    if (rst) begin
      sizes.x <= DIM_W'(MAX_DIM);
      sizes.y <= DIM_W'(MAX_DIM);
      sizes.z <= DIM_W'(MAX_DIM);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SIZE_X: sizes.x <= cfg_data;
        REG_SIZE_Y: sizes.y <= cfg_data;
        REG_SIZE_Z: sizes.z <= cfg_data;
        default: ;
      endcase
    end
  end

  assign inflight     = busy || !empty;
  assign oldest_waddr = busy ? busy_waddr : head.waddr;

  vns_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sizes        (sizes),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .fraction     (fraction),
    .hist_wr      (hist_wr),
    .push         (push),
    .push_job     (push_job),
    .q_full       (q_full),
    .inflight     (inflight),
    .oldest_waddr (oldest_waddr)
  );

  vns_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  vns_back u_back (
    .clk        (clk),
    .rst        (rst),
    .hist_wr    (hist_wr),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .busy       (busy),
    .busy_waddr (busy_waddr),
    .grad_valid (grad_valid),
    .grad       (grad),
    .grad_ready (grad_ready)
  );

  vns_norm u_norm (
    .clk           (clk),
    .rst           (rst),
    .grad_valid    (grad_valid),
    .grad          (grad),
    .grad_ready    (grad_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .normal_x      (normal_x),
    .normal_y      (normal_y),
    .normal_z      (normal_z),
    .cell_x        (cell_x),
    .cell_y        (cell_y),
    .cell_z        (cell_z),
    .zero_gradient (zero_gradient),
    .last_cell     (last_cell)
  );

endmodule
